[design/pimb_pkg.sv]
// ----------------------------------------------------------------------------
// pimb_pkg
// Shared types and constants of the priority-inheritance mutex bank: request
// and result records, the per-mutex entry and the operation and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package pimb_pkg;

  // Bank geometry
  localparam int NUM_MUTEXES   = 16;
  localparam int COUNT_WIDTH   = 8;
  localparam int TASK_ID_WIDTH = 8;

  // Fixed field widths of the channels
  localparam int FUNC_WIDTH   = 2;
  localparam int INDEX_WIDTH  = 4;
  localparam int TASK_WIDTH   = 8;
  localparam int PRIO_WIDTH   = 8;
  localparam int STATUS_WIDTH = 2;

  // Entry addressing
  localparam int SLOT_WIDTH = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
  localparam logic [INDEX_WIDTH:0] MUTEX_LIMIT = (INDEX_WIDTH + 1)'(NUM_MUTEXES);

  // Operation codes
  localparam logic [FUNC_WIDTH-1:0] FUNC_LOCK   = 2'd0;
  localparam logic [FUNC_WIDTH-1:0] FUNC_TRY    = 2'd1;
  localparam logic [FUNC_WIDTH-1:0] FUNC_UNLOCK = 2'd2;

  // Status codes
  localparam logic [STATUS_WIDTH-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_BUSY    = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_TIMEOUT = 2'd2;
  localparam logic [STATUS_WIDTH-1:0] ST_INVALID = 2'd3;

  typedef logic [SLOT_WIDTH-1:0] slot_t;

  // One mutex of the bank
  typedef struct packed {
    logic                     held;
    logic [COUNT_WIDTH-1:0]   depth;
    logic [TASK_ID_WIDTH-1:0] owner;
    logic [PRIO_WIDTH-1:0]    saved_prio;
    logic [PRIO_WIDTH-1:0]    owner_prio;
  } entry_t;

  // Write port of the entry bank
  typedef struct packed {
    logic   we;
    slot_t  slot;
    entry_t entry;
  } upd_t;

  // One request
  typedef struct packed {
    logic [FUNC_WIDTH-1:0]  func;
    logic [INDEX_WIDTH-1:0] mutex_index;
    logic [TASK_WIDTH-1:0]  task_id;
    logic [PRIO_WIDTH-1:0]  task_priority;
    logic [PRIO_WIDTH-1:0]  task_base_priority;
  } req_t;

  // One result
  typedef struct packed {
    logic [STATUS_WIDTH-1:0] status;
    logic                    prio_change;
    logic [TASK_WIDTH-1:0]   change_task;
    logic [PRIO_WIDTH-1:0]   change_priority;
  } rsp_t;

endpackage

`default_nettype wire

[design/pimb_if.sv]
// ----------------------------------------------------------------------------
// pimb_if
// Valid/ready channels of the mutex bank: the request channel and the result
// channel, each with a source and a sink view.
// ----------------------------------------------------------------------------
`default_nettype none

interface pimb_req_if;
  logic                            valid;
  logic                            ready;
  logic [pimb_pkg::FUNC_WIDTH-1:0]  func;
  logic [pimb_pkg::INDEX_WIDTH-1:0] mutex_index;
  logic [pimb_pkg::TASK_WIDTH-1:0]  task_id;
  logic [pimb_pkg::PRIO_WIDTH-1:0]  task_priority;
  logic [pimb_pkg::PRIO_WIDTH-1:0]  task_base_priority;

  modport source (
    output valid, func, mutex_index, task_id, task_priority, task_base_priority,
    input  ready
  );
  modport sink (
    input  valid, func, mutex_index, task_id, task_priority, task_base_priority,
    output ready
  );
endinterface

interface pimb_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [pimb_pkg::STATUS_WIDTH-1:0] status;
  logic                             prio_change;
  logic [pimb_pkg::TASK_WIDTH-1:0]   change_task;
  logic [pimb_pkg::PRIO_WIDTH-1:0]   change_priority;

  modport source (
    output valid, status, prio_change, change_task, change_priority,
    input  ready
  );
  modport sink (
    input  valid, status, prio_change, change_task, change_priority,
    output ready
  );
endinterface

`default_nettype wire

[design/pimb_entry_bank.sv]
// ----------------------------------------------------------------------------
// pimb_entry_bank
// Register file of the mutex entries: one combinational read at the slot of
// the request in flight, one write of its updated entry.
// ----------------------------------------------------------------------------
`default_nettype none

module pimb_entry_bank (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire pimb_pkg::slot_t  rd_slot,
  output pimb_pkg::entry_t      rd_entry,
  input  wire pimb_pkg::upd_t   upd
);
  import pimb_pkg::*;

  entry_t entry_r [NUM_MUTEXES];

  // Read the addressed mutex
  assign rd_entry = entry_r[rd_slot];

  // Clear on reset, write back the updated entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_MUTEXES; i++) begin
        entry_r[i] <= '0;
      end
    end else if (upd.we) begin
      entry_r[upd.slot] <= upd.entry;
    end
  end

endmodule

`default_nettype wire

[design/pimb_decide.sv]
// ----------------------------------------------------------------------------
// pimb_decide
// Lock, try-lock and unlock decision for one request against its mutex
// entry: produces the result and the updated entry.
// ----------------------------------------------------------------------------
`default_nettype none

module pimb_decide (
  input  wire pimb_pkg::req_t   req,
  input  wire pimb_pkg::entry_t cur,
  output pimb_pkg::entry_t      nxt,
  output logic                  we,
  output pimb_pkg::rsp_t        rsp
);
  import pimb_pkg::*;

  logic                     in_range;
  logic [TASK_ID_WIDTH-1:0] tid;
  logic                     is_owner;
  logic                     depth_full;
  logic [PRIO_WIDTH-1:0]    target;

  assign in_range   = {1'b0, req.mutex_index} < MUTEX_LIMIT;
  assign tid        = req.task_id[TASK_ID_WIDTH-1:0];
  assign is_owner   = cur.owner == tid;
  assign depth_full = &cur.depth;
  assign target     = (req.task_base_priority != '0) ? req.task_base_priority
                                                     : cur.saved_prio;

  always_comb begin
    nxt = cur;
    we  = 1'b0;
    rsp = '{status: ST_INVALID, prio_change: 1'b0, change_task: '0,
            change_priority: '0};
    if (in_range) begin
      case (req.func)
        FUNC_LOCK, FUNC_TRY: begin
          if (!cur.held) begin
            // Take a free mutex
            nxt.held       = 1'b1;
            nxt.depth      = COUNT_WIDTH'(1);
            nxt.owner      = tid;
            nxt.saved_prio = req.task_priority;
            nxt.owner_prio = req.task_priority;
            we             = 1'b1;
            rsp.status     = ST_OK;
          end else if (is_owner) begin
            // Nest, saturating at the top of the count
            if (!depth_full) begin
              nxt.depth  = cur.depth + COUNT_WIDTH'(1);
              we         = 1'b1;
              rsp.status = ST_OK;
            end
          end else if (req.func == FUNC_TRY) begin
            rsp.status = ST_TIMEOUT;
          end else begin
            // Contended wait: lend the owner a higher priority
            rsp.status = ST_BUSY;
            if (req.task_priority > cur.owner_prio) begin
              nxt.owner_prio      = req.task_priority;
              we                  = 1'b1;
              rsp.prio_change     = 1'b1;
              rsp.change_task     = TASK_WIDTH'(cur.owner);
              rsp.change_priority = req.task_priority;
            end
          end
        end
        FUNC_UNLOCK: begin
          if (cur.held && is_owner) begin
            rsp.status = ST_OK;
            we         = 1'b1;
            if (cur.depth > COUNT_WIDTH'(1)) begin
              nxt.depth = cur.depth - COUNT_WIDTH'(1);
            end else begin
              // Final release: free the mutex, restore the owner priority
              nxt.held       = 1'b0;
              nxt.depth      = '0;
              nxt.owner      = '0;
              nxt.owner_prio = '0;
              if (target != req.task_priority) begin
                rsp.prio_change     = 1'b1;
                rsp.change_task     = TASK_WIDTH'(cur.owner);
                rsp.change_priority = target;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[design/priority_inheritance_mutex_bank_top.sv]
// ----------------------------------------------------------------------------
// priority_inheritance_mutex_bank_top
// Bank of recursive mutexes with priority inheritance behind valid/ready
// request and result channels.
// ----------------------------------------------------------------------------
// Takes one request per clock while results are not stalled, and returns
// one result per request, in order. A request is held in an input register;
// there it reads its mutex entry, and when it moves on it is decided and
// written back in the same cycle, and its result lands in the output
// register, from which it can be taken when the result channel is not
// stalled. The rate of one request per cycle while results are not stalled
// is set by the single read-modify-write of the entry
// registers; a later request always sees the entry left by an earlier one.
// The result register holds a stalled result while the input register still
// takes a new request if it is empty. All mutexes are free after reset.
`default_nettype none

module priority_inheritance_mutex_bank_top (
  input  wire logic   clk,
  input  wire logic   rst_n,
  pimb_req_if.sink    in_req,
  pimb_rsp_if.source  out_rsp
);
  import pimb_pkg::*;

  logic   s1_valid_r;
  req_t   s1_req_r;
  logic   out_valid_r;
  rsp_t   out_rsp_r;
  logic   advance;
  entry_t cur_entry;
  entry_t nxt_entry;
  logic   entry_we;
  rsp_t   dec_rsp;
  upd_t   upd;

  // Move a request on when the result register is free or being emptied
  assign advance      = s1_valid_r && (!out_valid_r || out_rsp.ready);
  assign in_req.ready = !s1_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      s1_valid_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      s1_req_r <= '{func: in_req.func, mutex_index: in_req.mutex_index,
                    task_id: in_req.task_id, task_priority: in_req.task_priority,
                    task_base_priority: in_req.task_base_priority};
    end
  end

  // Entry registers and decision
  pimb_entry_bank u_bank (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_slot  (s1_req_r.mutex_index[SLOT_WIDTH-1:0]),
    .rd_entry (cur_entry),
    .upd      (upd)
  );

  pimb_decide u_decide (
    .req (s1_req_r),
    .cur (cur_entry),
    .nxt (nxt_entry),
    .we  (entry_we),
    .rsp (dec_rsp)
  );

  assign upd = '{we: advance && entry_we,
                 slot: s1_req_r.mutex_index[SLOT_WIDTH-1:0],
                 entry: nxt_entry};

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_rsp.ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rsp_r <= dec_rsp;
    end
  end

  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.status          = out_rsp_r.status;
  assign out_rsp.prio_change     = out_rsp_r.prio_change;
  assign out_rsp.change_task     = out_rsp_r.change_task;
  assign out_rsp.change_priority = out_rsp_r.change_priority;

endmodule

`default_nettype wire

[design/pimb_checker.sv]
// ----------------------------------------------------------------------------
// pimb_checker
// Port-level checks of the mutex bank: result channel handshake and the
// consistency of the priority-change fields with the status.
// ----------------------------------------------------------------------------
`default_nettype none

module pimb_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [pimb_pkg::STATUS_WIDTH-1:0] out_status,
  input wire logic                              out_prio_change,
  input wire logic [pimb_pkg::TASK_WIDTH-1:0]   out_change_task,
  input wire logic [pimb_pkg::PRIO_WIDTH-1:0]   out_change_priority
);
  import pimb_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // No result straight out of reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Without a change the change fields stay zero
  a_no_change_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_prio_change |-> out_change_task == '0 &&
                                      out_change_priority == '0)
    else $error("change fields set without a priority change");

  // A priority change only comes with busy or ok
  a_change_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_prio_change |-> out_status == ST_BUSY || out_status == ST_OK)
    else $error("priority change with timeout or invalid status");

endmodule

bind priority_inheritance_mutex_bank_top pimb_checker u_pimb_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_rsp.valid),
  .out_ready           (out_rsp.ready),
  .out_status          (out_rsp.status),
  .out_prio_change     (out_rsp.prio_change),
  .out_change_task     (out_rsp.change_task),
  .out_change_priority (out_rsp.change_priority)
);

`default_nettype wire
